// ----- design/itrcf_pkg.sv -----
// Package for the IMU tilt/roll complementary filter.
// Holds widths, register addresses, CORDIC arctangent table and IIR coefficients.
// No dependencies.
package itrcf_pkg;

    localparam int DefaultFilterTaps   = 4;
    localparam int DefaultAngleFracBits = 20;
    localparam int MaxTaps     = 8;
    localparam int CoefFrac    = 24;
    localparam int CordicSteps = 28;
    localparam int CordicFrac  = 30;
    localparam int QueueDepth  = 2;

    localparam int PaddrW = 4;
    localparam logic [PaddrW-1:0] ADDR_OFFSET_X = 4'h0;
    localparam logic [PaddrW-1:0] ADDR_OFFSET_Y = 4'h4;
    localparam logic [PaddrW-1:0] ADDR_STEP_GAIN = 4'h8;

    localparam logic signed [15:0] OFFSET_X_RESET = -16'sd1942;
    localparam logic signed [15:0] OFFSET_Y_RESET = -16'sd1474;
    localparam logic [23:0] STEP_GAIN_RESET = 24'd555268;

    // Sample handed from the front end to the back end
    typedef struct packed {
        logic signed [15:0] accel_x;
        logic signed [15:0] accel_y;
        logic signed [15:0] accel_z;
        logic signed [16:0] gyro_dx;
        logic signed [16:0] gyro_dy;
        logic               zero_tilt;
        logic               zero_roll;
    } sample_t;

    typedef enum logic [3:0] {
        ST_IDLE,
        ST_SQRT,
        ST_CORDIC,
        ST_ROUND,
        ST_GYRO,
        ST_GYRO_ADD,
        ST_FILT,
        ST_FILT_ACC,
        ST_FILT_DONE,
        ST_SUM,
        ST_OUT
    } be_state_t;

    function automatic logic [31:0] atan_entry(input logic [4:0] i);
        logic [31:0] r;
        begin
            unique case (i)
                5'd0:  r = 32'h3243F6A8;
                5'd1:  r = 32'h1DAC6705;
                5'd2:  r = 32'h0FADBAFC;
                5'd3:  r = 32'h07F56EA6;
                5'd4:  r = 32'h03FEAB76;
                5'd5:  r = 32'h01FFD55B;
                5'd6:  r = 32'h00FFFAAA;
                5'd7:  r = 32'h007FFF55;
                5'd8:  r = 32'h003FFFEA;
                5'd9:  r = 32'h001FFFFD;
                5'd10: r = 32'h000FFFFF;
                5'd11: r = 32'h0007FFFF;
                5'd12: r = 32'h0003FFFF;
                5'd13: r = 32'h0001FFFF;
                5'd14: r = 32'h0000FFFF;
                5'd15: r = 32'h00007FFF;
                5'd16: r = 32'h00003FFF;
                5'd17: r = 32'h00001FFF;
                5'd18: r = 32'h00000FFF;
                5'd19: r = 32'h000007FF;
                5'd20: r = 32'h000003FF;
                5'd21: r = 32'h000001FF;
                5'd22: r = 32'h000000FF;
                5'd23: r = 32'h0000007F;
                5'd24: r = 32'h0000003F;
                5'd25: r = 32'h0000001F;
                5'd26: r = 32'h0000000F;
                5'd27: r = 32'h00000008;
                default: r = 32'h0;
            endcase
            return r;
        end
    endfunction

    // Coefficients with 24 fraction bits; den is returned already negated.
    // kind: 0 lp num, 1 lp -den, 2 hp num, 3 hp -den
    function automatic logic signed [26:0] coef(input logic [1:0] kind, input logic [2:0] i);
        logic signed [26:0] r;
        begin
            r = '0;
            unique case (kind)
                2'd0: unique case (i)
                    3'd0: r = 27'sd293601;
                    3'd1: r = -27'sd286890;
                    3'd2: r = -27'sd286890;
                    3'd3: r = 27'sd293601;
                    default: r = '0;
                endcase
                2'd1: unique case (i)
                    3'd1: r = 27'sd47377180;
                    3'd2: r = -27'sd44669338;
                    3'd3: r = 27'sd14057629;
                    default: r = '0;
                endcase
                2'd2: unique case (i)
                    3'd0: r = 27'sd16007142;
                    3'd1: r = -27'sd48021425;
                    3'd2: r = 27'sd48021425;
                    3'd3: r = -27'sd16007142;
                    default: r = '0;
                endcase
                default: unique case (i)
                    3'd1: r = 27'sd48768011;
                    3'd2: r = -27'sd47253029;
                    3'd3: r = 27'sd15260556;
                    default: r = '0;
                endcase
            endcase
            return r;
        end
    endfunction

    function automatic logic signed [31:0] sat32(input logic signed [63:0] v);
        logic signed [31:0] r;
        begin
            if (v > 64'sd2147483647)
                r = 32'sh7FFFFFFF;
            else if (v < -64'sd2147483648)
                r = 32'sh80000000;
            else
                r = v[31:0];
            return r;
        end
    endfunction

endpackage

// ----- design/imu_tilt_roll_complementary_filter_top.sv -----
// From input transaction to result valid with an idle back end, a sample passes the queue,
// two square roots and two 28-step CORDIC passes, each followed by a rounding state, gyro
// scaling of both axes, four IIR filters on one shared multiplier, a sum state and an output
// state. The back end takes a new sample only once the previous result has been taken; a
// two-entry queue takes further samples meanwhile. Reset clears filter history and rate
// integrals and presets the registers. Depends on itrcf_pkg, itrcf_front, itrcf_back.
module imu_tilt_roll_complementary_filter_top #(
    parameter int FILTER_TAPS     = itrcf_pkg::DefaultFilterTaps,
    parameter int ANGLE_FRAC_BITS = itrcf_pkg::DefaultAngleFracBits
) (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          in_valid,
    output logic                          in_ready,
    input  logic signed [15:0]            accel_x,
    input  logic signed [15:0]            accel_y,
    input  logic signed [15:0]            accel_z,
    input  logic signed [15:0]            gyro_x,
    input  logic signed [15:0]            gyro_y,
    output logic                          out_valid,
    input  logic                          out_ready,
    output logic signed [31:0]            roll_angle,
    output logic signed [31:0]            tilt_angle,
    input  logic                          psel,
    input  logic                          penable,
    input  logic                          pwrite,
    input  logic [itrcf_pkg::PaddrW-1:0]  paddr,
    input  logic [31:0]                   pwdata,
    output logic [31:0]                   prdata,
    output logic                          pready
);
    import itrcf_pkg::*;

    logic signed [15:0] offset_x_reg, offset_y_reg;
    logic [23:0]        gain_reg;
    logic               q_valid, q_ready;
    sample_t            q_data;
    logic               wr;

    assign pready = 1'b1;
    assign wr = psel && penable && pwrite;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            offset_x_reg <= OFFSET_X_RESET;
            offset_y_reg <= OFFSET_Y_RESET;
            gain_reg     <= STEP_GAIN_RESET;
        end
        else if (wr)
        begin
            unique case (paddr)
                ADDR_OFFSET_X:  offset_x_reg <= pwdata[15:0];
                ADDR_OFFSET_Y:  offset_y_reg <= pwdata[15:0];
                ADDR_STEP_GAIN: gain_reg     <= pwdata[23:0];
                default: ;
            endcase
        end
    end

    always_comb
    begin
        unique case (paddr)
            ADDR_OFFSET_X:  prdata = 32'(offset_x_reg);
            ADDR_OFFSET_Y:  prdata = 32'(offset_y_reg);
            ADDR_STEP_GAIN: prdata = {8'd0, gain_reg};
            default:        prdata = '0;
        endcase
    end

    itrcf_front u_front (
        .clk      (clk),
        .rst_n    (rst_n),
        .valid    (in_valid),
        .ready    (in_ready),
        .accel_x  (accel_x),
        .accel_y  (accel_y),
        .accel_z  (accel_z),
        .gyro_x   (gyro_x),
        .gyro_y   (gyro_y),
        .offset_x (offset_x_reg),
        .offset_y (offset_y_reg),
        .q_valid  (q_valid),
        .q_ready  (q_ready),
        .q_data   (q_data)
    );

    itrcf_back #(
        .FILTER_TAPS     (FILTER_TAPS),
        .ANGLE_FRAC_BITS (ANGLE_FRAC_BITS)
    ) u_back (
        .clk        (clk),
        .rst_n      (rst_n),
        .q_valid    (q_valid),
        .q_ready    (q_ready),
        .q_data     (q_data),
        .step_gain  (gain_reg),
        .valid      (out_valid),
        .ready      (out_ready),
        .roll_angle (roll_angle),
        .tilt_angle (tilt_angle)
    );

endmodule

// ----- design/itrcf_front.sv -----
// Front end: accepts samples, offset-corrects gyro, flags zero atan2 vectors, queues items.
// Depends on itrcf_pkg.
module itrcf_front (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               valid,
    output logic               ready,
    input  logic signed [15:0] accel_x,
    input  logic signed [15:0] accel_y,
    input  logic signed [15:0] accel_z,
    input  logic signed [15:0] gyro_x,
    input  logic signed [15:0] gyro_y,
    input  logic signed [15:0] offset_x,
    input  logic signed [15:0] offset_y,
    output logic               q_valid,
    input  logic               q_ready,
    output itrcf_pkg::sample_t q_data
);
    import itrcf_pkg::*;

    localparam int PtrW = $clog2(QueueDepth);

    sample_t          mem [QueueDepth];
    logic [PtrW-1:0]  wr_ptr_reg, wr_ptr_next, rd_ptr_reg, rd_ptr_next;
    logic [PtrW:0]    count_reg, count_next;
    sample_t          in_item;
    logic             push, pop;

    always_comb
    begin
        in_item.accel_x = accel_x;
        in_item.accel_y = accel_y;
        in_item.accel_z = accel_z;
        in_item.gyro_dx = 17'(gyro_x) - 17'(offset_x);
        in_item.gyro_dy = 17'(gyro_y) - 17'(offset_y);
        // atan2 is forced to zero when numerator and the root both vanish
        in_item.zero_tilt = (accel_x == '0) && (accel_y == '0) && (accel_z == '0);
        in_item.zero_roll = in_item.zero_tilt;
    end

    assign ready   = (count_reg != (PtrW+1)'(QueueDepth));
    assign q_valid = (count_reg != '0);
    assign q_data  = mem[rd_ptr_reg];
    assign push    = valid && ready;
    assign pop     = q_valid && q_ready;

    always_comb
    begin
        wr_ptr_next = push ? wr_ptr_reg + 1'b1 : wr_ptr_reg;
        rd_ptr_next = pop ? rd_ptr_reg + 1'b1 : rd_ptr_reg;
        count_next  = count_reg + (PtrW+1)'(push) - (PtrW+1)'(pop);
    end

    always_ff @(posedge clk)
    begin
        if (push)
            mem[wr_ptr_reg] <= in_item;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

endmodule

// ----- design/itrcf_sqrt.sv -----
// Iterative integer square root, one result bit per cycle.
// Depends on itrcf_pkg.
module itrcf_sqrt (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        start,
    input  logic [47:0] radicand,
    output logic        done,
    output logic [23:0] root
);
    import itrcf_pkg::*;

    logic [47:0] rem_reg, rem_next;
    logic [23:0] root_reg, root_next;
    logic [47:0] val_reg, val_next;
    logic [4:0]  cnt_reg, cnt_next;
    logic        busy_reg, busy_next;
    logic [49:0] trial, rem_sh;

    always_comb
    begin
        rem_next  = rem_reg;
        root_next = root_reg;
        val_next  = val_reg;
        cnt_next  = cnt_reg;
        busy_next = busy_reg;
        rem_sh    = {rem_reg, val_reg[47:46]};
        trial     = {24'd0, root_reg, 2'b01};
        if (start)
        begin
            rem_next  = '0;
            root_next = '0;
            val_next  = radicand;
            cnt_next  = '0;
            busy_next = 1'b1;
        end
        else if (busy_reg)
        begin
            val_next = {val_reg[45:0], 2'b00};
            if (rem_sh >= trial)
            begin
                rem_next  = 48'(rem_sh - trial);
                root_next = {root_reg[22:0], 1'b1};
            end
            else
            begin
                rem_next  = rem_sh[47:0];
                root_next = {root_reg[22:0], 1'b0};
            end
            cnt_next = cnt_reg + 1'b1;
            if (cnt_reg == 5'd23)
                busy_next = 1'b0;
        end
    end

    assign done = busy_reg && (cnt_reg == 5'd23);
    assign root = root_next;

    always_ff @(posedge clk)
    begin
        rem_reg  <= rem_next;
        root_reg <= root_next;
        val_reg  <= val_next;
        cnt_reg  <= cnt_next;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            busy_reg <= 1'b0;
        else
            busy_reg <= busy_next;
    end

endmodule

// ----- design/itrcf_back.sv -----
// Back end: sqrt, CORDIC atan2, gyro integration, shared IIR MAC and output register.
// Depends on itrcf_pkg and itrcf_sqrt.
module itrcf_back #(
    parameter int FILTER_TAPS     = itrcf_pkg::DefaultFilterTaps,
    parameter int ANGLE_FRAC_BITS = itrcf_pkg::DefaultAngleFracBits
) (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               q_valid,
    output logic               q_ready,
    input  itrcf_pkg::sample_t q_data,
    input  logic [23:0]        step_gain,
    output logic               valid,
    input  logic               ready,
    output logic signed [31:0] roll_angle,
    output logic signed [31:0] tilt_angle
);
    import itrcf_pkg::*;

    localparam int Hist  = FILTER_TAPS - 1;
    localparam int TapW  = $clog2(FILTER_TAPS + 1);
    localparam int GainShift = 32 - ANGLE_FRAC_BITS;
    localparam int ZShift = CordicFrac - ANGLE_FRAC_BITS;

    be_state_t state_reg, state_next;
    sample_t   item_reg;
    logic      ang_sel_reg;          // 0 tilt, 1 roll
    logic [1:0] filt_sel_reg;        // 0 roll lp, 1 tilt lp, 2 roll hp, 3 tilt hp
    logic [4:0] step_reg;
    logic       ax_sel_reg;          // gyro axis 0 roll 1 tilt
    logic [TapW-1:0] tap_reg;
    logic       half_reg;            // 0 numerator term, 1 feedback term

    logic signed [31:0] hx_reg [4][Hist];
    logic signed [31:0] hy_reg [4][Hist];
    logic signed [31:0] acc_in [4];
    logic signed [31:0] accel_ang_reg [2];
    logic signed [31:0] rate_int_reg [2];
    logic signed [31:0] filt_out_reg [4];

    logic signed [33:0] cx_reg, cy_reg;
    logic signed [31:0] cz_reg;
    logic signed [63:0] mac_reg;
    logic signed [63:0] prod_reg;
    logic signed [31:0] out_roll_reg, out_tilt_reg;
    logic               out_valid_reg;

    logic        sq_start, sq_done;
    logic [23:0] sq_root;
    logic signed [31:0] a_op, b_op;
    logic [47:0] radicand;

    sample_t q_item;
    assign q_item = q_data;

    // tilt root (y,z) starts from the queue head, roll root (x,z) from the held item
    always_comb
    begin
        if (state_reg == ST_IDLE)
        begin
            a_op = 32'(q_item.accel_y);
            b_op = 32'(q_item.accel_z);
        end
        else
        begin
            a_op = 32'(item_reg.accel_x);
            b_op = 32'(item_reg.accel_z);
        end
        radicand = {(32'(a_op * a_op) + 32'(b_op * b_op)), 16'd0};
    end

    itrcf_sqrt u_sqrt (
        .clk      (clk),
        .rst_n    (rst_n),
        .start    (sq_start),
        .radicand (radicand),
        .done     (sq_done),
        .root     (sq_root)
    );

    logic signed [33:0] xs, ys;
    assign xs = cx_reg >>> step_reg;
    assign ys = cy_reg >>> step_reg;

    logic signed [31:0] cur_x_hist;
    logic signed [31:0] cur_y_hist;
    logic signed [26:0] cur_coef;
    logic signed [31:0] cur_sample;
    always_comb
    begin
        cur_x_hist = '0;
        cur_y_hist = '0;
        for (int k = 0; k < Hist; k++)
        begin
            if (32'(tap_reg) == k + 1)
            begin
                cur_x_hist = hx_reg[filt_sel_reg][k];
                cur_y_hist = hy_reg[filt_sel_reg][k];
            end
        end
        if (half_reg)
            cur_sample = cur_y_hist;
        else if (tap_reg == '0)
            cur_sample = acc_in[filt_sel_reg];
        else
            cur_sample = cur_x_hist;
        cur_coef = coef({filt_sel_reg[1], half_reg}, 3'(tap_reg));
    end

    logic signed [63:0] rnd;
    logic signed [31:0] filt_res;
    assign rnd = (mac_reg + (64'sd1 <<< (CoefFrac - 1))) >>> CoefFrac;
    assign filt_res = sat32(rnd);

    logic signed [63:0] zr;
    assign zr = (64'(cz_reg) + (64'sd1 <<< (ZShift - 1))) >>> ZShift;

    logic signed [16:0] gyro_d;
    assign gyro_d = ax_sel_reg ? item_reg.gyro_dy : item_reg.gyro_dx;
    logic signed [63:0] gstep;
    assign gstep = (prod_reg + (64'sd1 <<< (GainShift - 1))) >>> GainShift;

    always_comb
    begin
        state_next = state_reg;
        q_ready    = 1'b0;
        sq_start   = 1'b0;
        unique case (state_reg)
            ST_IDLE:
                if (q_valid && !out_valid_reg)
                begin
                    q_ready  = 1'b1;
                    state_next = ST_SQRT;
                    sq_start = 1'b1;
                end
            ST_SQRT:
                if (sq_done)
                    state_next = ST_CORDIC;
            ST_CORDIC:
                if (step_reg == 5'(CordicSteps - 1))
                    state_next = ST_ROUND;
            ST_ROUND:
            begin
                if (ang_sel_reg)
                    state_next = ST_GYRO;
                else
                begin
                    state_next = ST_SQRT;
                    sq_start = 1'b1;
                end
            end
            ST_GYRO:     state_next = ST_GYRO_ADD;
            ST_GYRO_ADD: state_next = ax_sel_reg ? ST_FILT : ST_GYRO;
            ST_FILT:     state_next = ST_FILT_ACC;
            ST_FILT_ACC:
                if (half_reg && tap_reg == TapW'(Hist))
                    state_next = ST_FILT_DONE;
                else
                    state_next = ST_FILT;
            ST_FILT_DONE: state_next = (filt_sel_reg == 2'd3) ? ST_SUM : ST_FILT;
            ST_SUM:      state_next = ST_OUT;
            ST_OUT:      state_next = ST_IDLE;
            default:     state_next = ST_IDLE;
        endcase
    end

    always_ff @(posedge clk)
    begin
        unique case (state_reg)
            ST_IDLE:
                if (q_valid && !out_valid_reg)
                begin
                    item_reg    <= q_item;
                    ang_sel_reg <= 1'b0;
                    ax_sel_reg  <= 1'b0;
                    filt_sel_reg <= '0;
                end
            ST_SQRT:
                if (sq_done)
                begin
                    cx_reg   <= 34'(sq_root);
                    cy_reg   <= ang_sel_reg ? -(34'(item_reg.accel_y) <<< 8)
                                            : (34'(item_reg.accel_x) <<< 8);
                    cz_reg   <= '0;
                    step_reg <= '0;
                end
            ST_CORDIC:
            begin
                if (cy_reg > 0)
                begin
                    cx_reg <= cx_reg + ys;
                    cy_reg <= cy_reg - xs;
                    cz_reg <= cz_reg + atan_entry(step_reg);
                end
                else
                begin
                    cx_reg <= cx_reg - ys;
                    cy_reg <= cy_reg + xs;
                    cz_reg <= cz_reg - atan_entry(step_reg);
                end
                step_reg <= step_reg + 1'b1;
            end
            ST_ROUND:
            begin
                // zero vector gives zero angle
                if (ang_sel_reg)
                    accel_ang_reg[0] <= item_reg.zero_roll ? '0 : sat32(zr);
                else
                    accel_ang_reg[1] <= item_reg.zero_tilt ? '0 : sat32(zr);
                ang_sel_reg <= 1'b1;
            end
            ST_GYRO:
                prod_reg <= 64'(gyro_d) * 64'($signed({1'b0, step_gain}));
            ST_GYRO_ADD:
            begin
                ax_sel_reg <= 1'b1;
                tap_reg    <= '0;
                half_reg   <= 1'b0;
                mac_reg    <= '0;
            end
            ST_FILT:
                prod_reg <= 64'(cur_coef) * 64'(cur_sample);
            ST_FILT_ACC:
            begin
                mac_reg <= mac_reg + prod_reg;
                if (!half_reg && tap_reg != '0)
                    half_reg <= 1'b1;
                else
                begin
                    half_reg <= 1'b0;
                    tap_reg  <= tap_reg + 1'b1;
                end
            end
            ST_FILT_DONE:
            begin
                filt_out_reg[filt_sel_reg] <= filt_res;
                filt_sel_reg <= filt_sel_reg + 1'b1;
                tap_reg  <= '0;
                half_reg <= 1'b0;
                mac_reg  <= '0;
            end
            ST_SUM:
            begin
                out_roll_reg <= sat32(64'(filt_out_reg[0]) + 64'(filt_out_reg[2]));
                out_tilt_reg <= sat32(64'(filt_out_reg[1]) + 64'(filt_out_reg[3]));
            end
            default: ;
        endcase
    end

    // state, valid, rate integrals (high-pass inputs) and history shift, with reset
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg       <= ST_IDLE;
            out_valid_reg   <= 1'b0;
            rate_int_reg[0] <= '0;
            rate_int_reg[1] <= '0;
            for (int f = 0; f < 4; f++)
                for (int k = 0; k < Hist; k++)
                begin
                    hx_reg[f][k] <= '0;
                    hy_reg[f][k] <= '0;
                end
        end
        else
        begin
            state_reg <= state_next;
            if (state_reg == ST_GYRO_ADD)
                rate_int_reg[ax_sel_reg] <= sat32(64'(rate_int_reg[ax_sel_reg]) + gstep);
            if (state_reg == ST_FILT_DONE)
            begin
                for (int k = Hist - 1; k > 0; k--)
                begin
                    hx_reg[filt_sel_reg][k] <= hx_reg[filt_sel_reg][k-1];
                    hy_reg[filt_sel_reg][k] <= hy_reg[filt_sel_reg][k-1];
                end
                hx_reg[filt_sel_reg][0] <= acc_in[filt_sel_reg];
                hy_reg[filt_sel_reg][0] <= filt_res;
            end
            if (state_reg == ST_OUT)
                out_valid_reg <= 1'b1;
            else if (out_valid_reg && ready)
                out_valid_reg <= 1'b0;
        end
    end

    always_comb
    begin
        acc_in[0] = accel_ang_reg[0];
        acc_in[1] = accel_ang_reg[1];
        acc_in[2] = rate_int_reg[0];
        acc_in[3] = rate_int_reg[1];
    end

    assign valid      = out_valid_reg;
    assign roll_angle = out_roll_reg;
    assign tilt_angle = out_tilt_reg;

endmodule

// ----- design/itrcf_checker.sv -----
// Port-level checker for the complementary filter top level, with its bind.
// Depends on itrcf_pkg and imu_tilt_roll_complementary_filter_top.
module itrcf_checker (
    input logic        clk,
    input logic        rst_n,
    input logic        in_valid,
    input logic        in_ready,
    input logic        out_valid,
    input logic        out_ready,
    input logic [31:0] roll_angle,
    input logic [31:0] tilt_angle,
    input logic        pready
);
    import itrcf_pkg::*;

    // hold result while stalled
    assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_ready |=> out_valid && $stable(roll_angle) && $stable(tilt_angle))
        else $error("result dropped while stalled");

    assert property (@(posedge clk) disable iff (!rst_n) pready)
        else $error("pready low");

    // no result is offered while reset is held
    assert property (@(posedge clk) !rst_n |-> !out_valid)
        else $error("result during reset");

endmodule

bind imu_tilt_roll_complementary_filter_top itrcf_checker u_checker (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_valid   (in_valid),
    .in_ready   (in_ready),
    .out_valid  (out_valid),
    .out_ready  (out_ready),
    .roll_angle (roll_angle),
    .tilt_angle (tilt_angle),
    .pready     (pready)
);
